// ===== rtl/core/chunked_byte_fifo_core_assert.svh =====
// Assertion macros for the chunked byte FIFO checker.
// Both sample on clk and are disabled while rst_n is low.
`ifndef CHUNKED_BYTE_FIFO_CORE_ASSERT_SVH
`define CHUNKED_BYTE_FIFO_CORE_ASSERT_SVH

// Same-cycle implication.
`define CBF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbf checker: same-cycle property failed");

// Next-cycle implication.
`define CBF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbf checker: next-cycle property failed");

`endif

// ===== rtl/core/cbf_pkg.sv =====
`timescale 1ns / 1ps

package cbf_pkg;

  localparam int LEN_W  = 13;
  localparam int BYTE_W = 8;
  localparam int FILL_W = 13;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_LEN  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_ROOM  = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_CHUNK = 2'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } cbf_mem_ctl_t;

endpackage

// ===== rtl/core/chunked_byte_fifo_core.sv =====
`timescale 1ns / 1ps
// Latency: a result strobes on out_valid in the cycle after its request is taken.
// Throughput: one request per cycle; busy stays low, the state update and the
// one store access of a request are both issued at the accepting edge.
// Reset: synchronous, active low; clears pointers, fill count and open chunks.
// The store keeps its contents across reset. Results cannot be stalled.
module chunked_byte_fifo_core #(
  parameter int DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic        in_first,
  input  logic [12:0] in_chunk_length,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [7:0]  out_read_byte,
  output logic        out_chunk_end,
  output logic [12:0] out_fill_level
);
  import cbf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cbf_mem_ctl_t      mem_ctl;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              read_hit;
  logic              req;

  assign busy = 1'b0;
  assign req  = start && !busy;

  cbf_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (req),
    .in_command     (in_command),
    .in_first       (in_first),
    .in_chunk_length(in_chunk_length),
    .mem_ctl        (mem_ctl),
    .wr_addr        (wr_addr),
    .rd_addr        (rd_addr),
    .res_valid      (out_valid),
    .res_read_hit   (read_hit),
    .res_status     (out_status),
    .res_chunk_end  (out_chunk_end),
    .res_fill_level (out_fill_level)
  );

  cbf_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .mem_ctl(mem_ctl),
    .wr_addr(wr_addr),
    .rd_addr(rd_addr),
    .wr_data(in_data_byte),
    .rd_data(rd_data)
  );

  assign out_read_byte = read_hit ? rd_data : '0;

endmodule

// ===== rtl/core/cbf_store.sv =====
`timescale 1ns / 1ps

module cbf_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                 clk,
  input  cbf_pkg::cbf_mem_ctl_t mem_ctl,
  input  logic [AW-1:0]        wr_addr,
  input  logic [AW-1:0]        rd_addr,
  input  logic [7:0]           wr_data,
  output logic [7:0]           rd_data
);
  import cbf_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/cbf_ctrl.sv =====
`timescale 1ns / 1ps

module cbf_ctrl #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int CW    = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req,
  input  logic                  in_command,
  input  logic                  in_first,
  input  logic [12:0]           in_chunk_length,
  output cbf_pkg::cbf_mem_ctl_t mem_ctl,
  output logic [AW-1:0]         wr_addr,
  output logic [AW-1:0]         rd_addr,
  output logic                  res_valid,
  output logic                  res_read_hit,
  output logic [1:0]            res_status,
  output logic                  res_chunk_end,
  output logic [12:0]           res_fill_level
);
  import cbf_pkg::*;

  localparam int XW = (CW > LEN_W) ? CW : LEN_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [XW-1:0] DEPTH_X   = XW'(DEPTH);

  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [LEN_W-1:0] wrem_r, wrem_nxt;
  logic [LEN_W-1:0] rrem_r, rrem_nxt;

  logic              valid_r, read_hit_r, end_r;
  logic [STAT_W-1:0] status_r;
  logic [FILL_W-1:0] fill_r;

  logic              is_read;
  logic [LEN_W-1:0]  rem_cur, rem_new;
  logic [XW-1:0]     len_x, count_x;
  logic [STAT_W-1:0] status;
  logic              move;

  assign is_read = (in_command == CMD_READ);
  assign rem_cur = is_read ? rrem_r : wrem_r;
  assign len_x   = XW'(in_chunk_length);
  assign count_x = XW'(count_r);

  always_comb begin
    status  = ST_OK;
    move    = 1'b0;
    rem_new = rem_cur;
    if (in_first) begin
      rem_new = '0;
      priority if (in_chunk_length == '0 || len_x > DEPTH_X) begin
        status = ST_BAD_LEN;
      end else if (is_read ? (count_x < len_x) : ((DEPTH_X - count_x) < len_x)) begin
        status = ST_NO_ROOM;
      end else begin
        move    = 1'b1;
        rem_new = in_chunk_length - LEN_W'(1);
      end
    end else if (rem_cur == '0) begin
      status = ST_NO_CHUNK;
    end else begin
      move    = 1'b1;
      rem_new = rem_cur - LEN_W'(1);
    end
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    wrem_nxt  = wrem_r;
    rrem_nxt  = rrem_r;
    if (req) begin
      if (is_read) begin
        rrem_nxt = rem_new;
      end else begin
        wrem_nxt = rem_new;
      end
      if (move && is_read) begin
        head_nxt  = (head_r == LAST_ADDR) ? '0 : head_r + AW'(1);
        count_nxt = count_r - CW'(1);
      end else if (move) begin
        tail_nxt  = (tail_r == LAST_ADDR) ? '0 : tail_r + AW'(1);
        count_nxt = count_r + CW'(1);
      end
    end
  end

  assign mem_ctl.wr_en = req && move && !is_read;
  assign mem_ctl.rd_en = req && move && is_read;
  assign wr_addr       = tail_r;
  assign rd_addr       = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      wrem_r     <= '0;
      rrem_r     <= '0;
      valid_r    <= 1'b0;
      read_hit_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      wrem_r     <= wrem_nxt;
      rrem_r     <= rrem_nxt;
      valid_r    <= req;
      read_hit_r <= req && move && is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (req) begin
      status_r <= status;
      end_r    <= move && (rem_new == '0);
      fill_r   <= FILL_W'(count_nxt);
    end
  end

  assign res_valid      = valid_r;
  assign res_read_hit   = read_hit_r;
  assign res_status     = status_r;
  assign res_chunk_end  = end_r;
  assign res_fill_level = fill_r;

endmodule

// ===== rtl/core/cbf_checker.sv =====
`timescale 1ns / 1ps
`include "chunked_byte_fifo_core_assert.svh"

module cbf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [7:0]  out_read_byte,
  input logic        out_chunk_end,
  input logic [12:0] out_fill_level
);
  import cbf_pkg::*;

  `CBF_ASSERT_NEXT(a_req_gives_result, start && !busy, out_valid)
  `CBF_ASSERT_NEXT(a_no_req_no_result, !(start && !busy), !out_valid)
  `CBF_ASSERT_NOW(a_refused_is_empty, out_valid && out_status != ST_OK, out_read_byte == '0 && !out_chunk_end)
  `CBF_ASSERT_NOW(a_refused_keeps_fill, out_valid && out_status != ST_OK && $past(out_valid) && $past(rst_n), out_fill_level == $past(out_fill_level))

endmodule

bind chunked_byte_fifo_core cbf_checker u_cbf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_read_byte (out_read_byte),
  .out_chunk_end (out_chunk_end),
  .out_fill_level(out_fill_level)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

class fifo_scoreboard;
  localparam int DEPTH = 4096;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic        chunk_end;
    logic [12:0] fill_level;
  } fifo_result_t;

  logic [7:0]   byte_mem [DEPTH];
  int unsigned  head_ptr;
  int unsigned  tail_ptr;
  int unsigned  held;
  int unsigned  wr_left;
  int unsigned  rd_left;
  fifo_result_t due_q [$];
  int           errors;

  function new();
    head_ptr = 0;
    tail_ptr = 0;
    held     = 0;
    wr_left  = 0;
    rd_left  = 0;
    errors   = 0;
  endfunction

  function int unsigned level();
    return held;
  endfunction

  function int outstanding();
    return due_q.size();
  endfunction

  function void note_request(logic cmd, logic first, logic [12:0] len, logic [7:0] data);
    int unsigned  left;
    bit           move;
    fifo_result_t r;
    left = (cmd == cbf_pkg::CMD_READ) ? rd_left : wr_left;
    r = '0;
    r.status = cbf_pkg::ST_OK;
    move = 1'b0;
    if (first) begin
      left = 0;
      if (len == 0 || len > DEPTH) begin
        r.status = cbf_pkg::ST_BAD_LEN;
      end else if ((cmd == cbf_pkg::CMD_READ) ? (held < len) : (DEPTH - held < len)) begin
        r.status = cbf_pkg::ST_NO_ROOM;
      end else begin
        left = len;
        move = 1'b1;
      end
    end else if (left == 0) begin
      r.status = cbf_pkg::ST_NO_CHUNK;
    end else begin
      move = 1'b1;
    end
    if (move) begin
      if (cmd == cbf_pkg::CMD_READ) begin
        r.read_byte = byte_mem[head_ptr];
        head_ptr = (head_ptr + 1 == DEPTH) ? 0 : head_ptr + 1;
        held--;
      end else begin
        byte_mem[tail_ptr] = data;
        tail_ptr = (tail_ptr + 1 == DEPTH) ? 0 : tail_ptr + 1;
        held++;
      end
      left--;
      if (left == 0) r.chunk_end = 1'b1;
    end
    if (cmd == cbf_pkg::CMD_READ) rd_left = left;
    else wr_left = left;
    r.fill_level = held[12:0];
    due_q.push_back(r);
  endfunction

  function void compare_field(string field, logic [12:0] want, logic [12:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: out_%s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  function void check_result(logic [1:0] status, logic [7:0] read_byte, logic chunk_end,
                             logic [12:0] fill_level);
    fifo_result_t r;
    if (due_q.size() == 0) begin
      errors++;
      $display("%0t: result with no request pending, expected none, actual status %0d fill %0d",
               $time, status, fill_level);
      return;
    end
    r = due_q.pop_front();
    compare_field("status", 13'(r.status), 13'(status));
    compare_field("read_byte", 13'(r.read_byte), 13'(read_byte));
    compare_field("chunk_end", 13'(r.chunk_end), 13'(chunk_end));
    compare_field("fill_level", r.fill_level, fill_level);
  endfunction
endclass

module tb;
  import cbf_pkg::*;

  localparam int DEPTH = 4096;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic        in_first;
  logic [12:0] in_chunk_length;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_read_byte;
  logic        out_chunk_end;
  logic [12:0] out_fill_level;

  fifo_scoreboard sb = new();
  int             idle_pct;
  int             sent;

  chunked_byte_fifo_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_first(in_first),
    .in_chunk_length(in_chunk_length),
    .in_data_byte(in_data_byte),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_read_byte(out_read_byte),
    .out_chunk_end(out_chunk_end),
    .out_fill_level(out_fill_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_result(out_status, out_read_byte, out_chunk_end, out_fill_level);
  end

  task automatic send_request(logic cmd, logic first, logic [12:0] len, logic [7:0] data);
    start           <= 1'b1;
    in_command      <= cmd;
    in_first        <= first;
    in_chunk_length <= len;
    in_data_byte    <= data;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_request(cmd, first, len, data);
    sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_chunk(logic cmd, int len);
    for (int i = 0; i < len; i++)
      send_request(cmd, i == 0, 13'(len), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_mixed(int wr_len, int rd_len, bit cut);
    int wl;
    int rl;
    bit wr_open;
    bit rd_open;
    bit pick_rd;
    wl = wr_len;
    rl = rd_len;
    wr_open = 1'b0;
    rd_open = 1'b0;
    while (wl > 0 || rl > 0) begin
      if (wl == 0) pick_rd = 1'b1;
      else if (rl == 0) pick_rd = 1'b0;
      else pick_rd = $urandom_range(0, 1);
      if (pick_rd) begin
        send_request(CMD_READ, !rd_open, 13'(rd_len), 8'($urandom_range(0, 255)));
        rd_open = 1'b1;
        rl--;
        if (cut && $urandom_range(0, 15) == 0) rl = 0;
      end else begin
        send_request(CMD_WRITE, !wr_open, 13'(wr_len), 8'($urandom_range(0, 255)));
        wr_open = 1'b1;
        wl--;
        if (cut && $urandom_range(0, 15) == 0) wl = 0;
      end
    end
  endtask

  task automatic drain_wait();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 8);
    if (r < 19) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  initial begin
    int wr_len;
    int rd_len;
    int r;
    int base;
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_command      = CMD_WRITE;
    in_first        = 1'b0;
    in_chunk_length = '0;
    in_data_byte    = '0;
    idle_pct        = 20;
    sent            = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_request(CMD_READ, 1'b0, 13'd5, 8'h00);
    send_request(CMD_WRITE, 1'b0, 13'd5, 8'h11);
    send_request(CMD_WRITE, 1'b1, 13'd0, 8'h22);
    send_request(CMD_READ, 1'b1, 13'd0, 8'h00);
    send_request(CMD_WRITE, 1'b1, 13'h1fff, 8'h33);
    send_request(CMD_WRITE, 1'b1, 13'd4097, 8'h44);
    send_request(CMD_READ, 1'b1, 13'd1, 8'h00);
    send_request(CMD_WRITE, 1'b1, 13'd3, 8'h00);
    send_request(CMD_WRITE, 1'b0, 13'd0, 8'hff);
    send_request(CMD_WRITE, 1'b0, 13'd0, 8'ha5);
    send_request(CMD_WRITE, 1'b0, 13'd0, 8'h5a);
    send_request(CMD_READ, 1'b1, 13'd4, 8'h00);
    send_request(CMD_READ, 1'b1, 13'd2, 8'hff);
    send_request(CMD_READ, 1'b0, 13'd0, 8'h00);
    send_request(CMD_WRITE, 1'b1, 13'd4096, 8'h66);
    send_request(CMD_WRITE, 1'b1, 13'd4095, 8'h77);
    send_request(CMD_WRITE, 1'b1, 13'd2, 8'h88);
    send_request(CMD_WRITE, 1'b0, 13'd0, 8'h99);
    send_request(CMD_READ, 1'b1, 13'd3, 8'h00);
    send_request(CMD_WRITE, 1'b1, 13'd1, 8'hcc);
    send_request(CMD_READ, 1'b0, 13'd0, 8'h00);
    send_request(CMD_READ, 1'b0, 13'd0, 8'h00);
    send_request(CMD_READ, 1'b1, 13'd4096, 8'h00);
    send_request(CMD_READ, 1'b1, 13'd2, 8'h00);
    send_request(CMD_READ, 1'b1, 13'd1, 8'h00);

    idle_pct = 0;
    send_chunk(CMD_WRITE, 100);
    send_chunk(CMD_READ, 100);
    send_request(CMD_WRITE, 1'b1, 13'd1, 8'hee);
    send_request(CMD_READ, 1'b1, 13'd4097, 8'h00);
    drain_wait();

    idle_pct = 20;
    base = sent;
    while (sent - base < 480) begin
      if (sent - base >= 420) idle_pct = 0;
      if ((sent - base) / 250 != (sent - base + 1) / 250) drain_wait();
      r = $urandom_range(0, 99);
      if (r < 72) begin
        wr_len = (sb.level() > DEPTH - 300 || $urandom_range(0, 4) == 0) ? 0 : pick_len();
        rd_len = ($urandom_range(0, 4) == 0) ? 0 : pick_len();
        if (sb.level() > 0 && $urandom_range(0, 3) != 0 && rd_len > sb.level())
          rd_len = sb.level();
        send_mixed(wr_len, rd_len, $urandom_range(0, 3) == 0);
      end else if (r < 87) begin
        send_request($urandom_range(0, 1), $urandom_range(0, 1), 13'($urandom_range(0, 8191)),
                     8'($urandom_range(0, 255)));
      end else if (r < 93) begin
        send_request($urandom_range(0, 1), 1'b1,
                     ($urandom_range(0, 1) == 0) ? 13'd0 : 13'($urandom_range(4097, 8191)),
                     8'($urandom_range(0, 255)));
      end else begin
        send_request(CMD_READ, 1'b1, 13'(sb.level() + $urandom_range(1, 8)),
                     8'($urandom_range(0, 255)));
      end
    end

    drain_wait();
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
